/* hw/rtl/epd_pkg.sv */
// Shared constants, types and codes for the escaped packet deframer.
package epd_pkg;

  localparam int BUF_BYTES   = 64;
  localparam int FRAME_EXTRA = 4;
  localparam int STORE_DEPTH = BUF_BYTES - FRAME_EXTRA;
  localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int LEN_W       = 6;
  localparam int CFG_IDX_W   = 8;

  typedef logic [7:0] byte_t;

  localparam byte_t START_CODE_RST  = 8'd255;
  localparam byte_t ESCAPE_CODE_RST = 8'd253;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_CODE  = 8'd0,
    CFG_ESCAPE_CODE = 8'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    P_HUNT,
    P_CMD,
    P_LEN,
    P_DATA
  } parse_state_t;

  typedef enum logic [1:0] {
    E_IDLE,
    E_READ,
    E_LOAD
  } emit_state_t;

  // Request from the parser to the emitter on a completed packet.
  typedef struct packed {
    logic             valid;
    byte_t            command;
    logic [LEN_W-1:0] length;
    logic             ok;
  } emit_req_t;

  // Payload store write port.
  typedef struct packed {
    logic                en;
    logic [STORE_AW-1:0] addr;
    byte_t               data;
  } store_wr_t;

endpackage

/* hw/rtl/epd_if.sv */
// Channel interfaces: link byte input, packet result output, register writes.
interface epd_in_if;
  import epd_pkg::*;
  logic  valid;
  logic  ready;
  byte_t rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface epd_out_if;
  import epd_pkg::*;
  logic             valid;
  logic             ready;
  byte_t            command;
  logic [LEN_W-1:0] payload_length;
  logic             has_data;
  byte_t            data_byte;
  logic [LEN_W-1:0] byte_index;
  logic             checksum_ok;
  logic             last;
  modport source (output valid, output command, output payload_length, output has_data,
                  output data_byte, output byte_index, output checksum_ok, output last,
                  input ready);
  modport sink (input valid, input command, input payload_length, input has_data,
                input data_byte, input byte_index, input checksum_ok, input last,
                output ready);
endinterface

interface epd_cfg_if;
  import epd_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  byte_t                data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/epd_ram.sv */
// Simple dual-port synchronous RAM with registered read data.
module epd_ram #(
  parameter int DEPTH = 60,
  parameter int WIDTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/epd_parser.sv */
// Frame parser: unescapes link bytes, tracks the checksum and fills the payload store.
module epd_parser (
  input  logic               clk,
  input  logic               rst_n,
  epd_in_if.sink             in_ch,
  epd_cfg_if.sink            cfg_ch,
  input  logic               busy,
  output epd_pkg::emit_req_t req,
  output epd_pkg::store_wr_t wr
);
  import epd_pkg::*;

  parse_state_t     state_r, state_nxt;
  logic             esc_r, esc_nxt;
  logic [STORE_AW-1:0] idx_r, idx_nxt;
  byte_t            cmd_r, cmd_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  byte_t            sum_r, sum_nxt;
  byte_t            start_code_r, escape_code_r;
  logic             accept;
  byte_t            val;

  assign in_ch.ready  = !busy;
  assign cfg_ch.ready = 1'b1;
  assign accept       = in_ch.valid && in_ch.ready;
  assign val          = in_ch.rx_byte + {7'd0, esc_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_code_r  <= START_CODE_RST;
      escape_code_r <= ESCAPE_CODE_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_START_CODE:  start_code_r  <= cfg_ch.data;
        CFG_ESCAPE_CODE: escape_code_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= P_HUNT;
      esc_r   <= 1'b0;
      idx_r   <= '0;
      cmd_r   <= '0;
      len_r   <= '0;
      sum_r   <= '0;
    end else begin
      state_r <= state_nxt;
      esc_r   <= esc_nxt;
      idx_r   <= idx_nxt;
      cmd_r   <= cmd_nxt;
      len_r   <= len_nxt;
      sum_r   <= sum_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    esc_nxt     = esc_r;
    idx_nxt     = idx_r;
    cmd_nxt     = cmd_r;
    len_nxt     = len_r;
    sum_nxt     = sum_r;
    req         = '0;
    req.command = cmd_r;
    req.length  = len_r;
    req.ok      = (8'(sum_r + val) == 8'd0);
    wr.en       = 1'b0;
    wr.addr     = idx_r;
    wr.data     = val;
    if (accept) begin
      if (in_ch.rx_byte == start_code_r) begin
        // start code always reopens a packet
        state_nxt = P_CMD;
        esc_nxt   = 1'b0;
        sum_nxt   = in_ch.rx_byte;
      end else if (state_r != P_HUNT) begin
        if (in_ch.rx_byte == escape_code_r) begin
          esc_nxt = 1'b1;
        end else begin
          esc_nxt = 1'b0;
          unique case (state_r)
            P_CMD: begin
              cmd_nxt   = val;
              sum_nxt   = 8'(sum_r + val);
              state_nxt = P_LEN;
            end
            P_LEN: begin
              sum_nxt = 8'(sum_r + val);
              len_nxt = val[LEN_W-1:0];
              idx_nxt = '0;
              // drop a packet that would not fit the store
              state_nxt = (val > 8'(STORE_DEPTH)) ? P_HUNT : P_DATA;
            end
            P_DATA: begin
              if (LEN_W'(idx_r) < len_r) begin
                wr.en   = 1'b1;
                sum_nxt = 8'(sum_r + val);
                idx_nxt = idx_r + 1'b1;
              end else begin
                req.valid = 1'b1;
                state_nxt = P_HUNT;
              end
            end
            default: state_nxt = P_HUNT;
          endcase
        end
      end
    end
  end

  a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> (int'(wr.addr) < STORE_DEPTH))
    else $error("payload write beyond store");

  a_req_len: assert property (@(posedge clk) disable iff (!rst_n)
    req.valid |-> (LEN_W'(idx_r) == len_r) && (int'(len_r) <= STORE_DEPTH))
    else $error("packet completed with wrong byte count");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !accept && !wr.en && !req.valid)
    else $error("parser active while results are being read out");

endmodule

/* hw/rtl/epd_emitter.sv */
// Result sequencer: reads the payload store back and drives the output register.
module epd_emitter (
  input  logic                       clk,
  input  logic                       rst_n,
  input  epd_pkg::emit_req_t         req,
  output logic                       busy,
  output logic [epd_pkg::STORE_AW-1:0] raddr,
  input  epd_pkg::byte_t             rdata,
  epd_out_if.source                  out_ch
);
  import epd_pkg::*;

  emit_state_t         state_r, state_nxt;
  logic [STORE_AW-1:0] k_r, k_nxt, k_inc;
  byte_t               cmd_r;
  logic [LEN_W-1:0]    len_r;
  logic                ok_r;
  logic                out_valid_r, out_valid_nxt;
  logic                load, slot_free, k_last, empty;

  byte_t            o_data_r;
  logic [LEN_W-1:0] o_index_r;
  logic             o_has_r, o_last_r;
  byte_t            o_cmd_r;
  logic [LEN_W-1:0] o_len_r;
  logic             o_ok_r;

  assign busy      = (state_r != E_IDLE);
  assign raddr     = k_r;
  assign k_inc     = k_r + 1'b1;
  assign empty     = (len_r == '0);
  assign k_last    = empty || (LEN_W'(k_inc) == len_r);
  assign slot_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= E_IDLE;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid) begin
      cmd_r <= req.command;
      len_r <= req.length;
      ok_r  <= req.ok;
    end
    if (load) begin
      o_cmd_r   <= cmd_r;
      o_len_r   <= len_r;
      o_ok_r    <= ok_r;
      o_has_r   <= !empty;
      o_data_r  <= empty ? 8'd0 : rdata;
      o_index_r <= empty ? '0 : LEN_W'(k_r);
      o_last_r  <= k_last;
    end
  end

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    load      = 1'b0;
    unique case (state_r)
      E_IDLE: begin
        if (req.valid) begin
          k_nxt     = '0;
          // an empty packet needs no store read
          state_nxt = (req.length == '0) ? E_LOAD : E_READ;
        end
      end
      E_READ: state_nxt = E_LOAD;
      E_LOAD: begin
        if (slot_free) begin
          load = 1'b1;
          if (k_last) begin
            state_nxt = E_IDLE;
          end else begin
            k_nxt     = k_inc;
            state_nxt = E_READ;
          end
        end
      end
      default: state_nxt = E_IDLE;
    endcase
    out_valid_nxt = load || (out_valid_r && !out_ch.ready);
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.command        = o_cmd_r;
  assign out_ch.payload_length = o_len_r;
  assign out_ch.has_data       = o_has_r;
  assign out_ch.data_byte      = o_data_r;
  assign out_ch.byte_index     = o_index_r;
  assign out_ch.checksum_ok    = o_ok_r;
  assign out_ch.last           = o_last_r;

  a_req_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.valid |-> state_r == E_IDLE)
    else $error("new packet while previous run still in progress");

  a_load_slot: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> slot_free)
    else $error("output overwritten before it was taken");

  a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != E_IDLE) && !empty |-> LEN_W'(k_r) < len_r)
    else $error("read index past packet length");

endmodule

/* hw/rtl/escaped_packet_deframer.sv */
// Top level of the escaped packet deframer: parser, payload store and result sequencer.
//
//  channel | dir | fields
//  in_ch   | in  | rx_byte[7:0]
//  out_ch  | out | command, payload_length, has_data, data_byte, byte_index, checksum_ok, last
//  cfg_ch  | in  | index[7:0] (0 start_code, 1 escape_code), data[7:0]; always ready
//
// Each link byte is taken in one cycle while no packet is being read out.
// A completed packet is read from the payload store one result at a time, through the read
// state (address) and the load state (registered read data); input stalls until the last result is loaded.
// Output back-pressure holds the result register and the store read index.
// Synchronous reset returns to hunting for a start code; the store needs no clearing.
module escaped_packet_deframer (
  input  logic    clk,
  input  logic    rst_n,
  epd_in_if.sink  in_ch,
  epd_out_if.source out_ch,
  epd_cfg_if.sink cfg_ch
);
  import epd_pkg::*;

  emit_req_t           req;
  store_wr_t           wr;
  logic                busy;
  logic [STORE_AW-1:0] raddr;
  byte_t               rdata;

  epd_parser u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .busy   (busy),
    .req    (req),
    .wr     (wr)
  );

  epd_ram #(
    .DEPTH (STORE_DEPTH),
    .WIDTH (8)
  ) u_store (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.addr),
    .wdata (wr.data),
    .raddr (raddr),
    .rdata (rdata)
  );

  epd_emitter u_emitter (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req),
    .busy   (busy),
    .raddr  (raddr),
    .rdata  (rdata),
    .out_ch (out_ch)
  );

endmodule

/* tb/tb_escaped_packet_deframer.sv */
// Testbench for the escaped packet deframer: scripted and random link traffic, checked per result.
module tb_escaped_packet_deframer;
  timeunit 1ns;
  timeprecision 1ps;
  import epd_pkg::*;

  localparam int HDR_BYTES       = 3;
  localparam int SETTLE_CYCLES   = 8;
  localparam int RANDOM_ITEMS    = 240;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int MAX_REPORTS     = 30;
  localparam logic [CFG_IDX_W-1:0] UNMAPPED_REG = 8'd2;

  typedef enum {SINK_OPEN, SINK_RANDOM, SINK_PATTERN} sink_mode_t;

  typedef byte_t byte_q_t[$];

  typedef struct {
    byte_t            command;
    logic [LEN_W-1:0] payload_length;
    logic             has_data;
    byte_t            data_byte;
    logic [LEN_W-1:0] byte_index;
    logic             checksum_ok;
    logic             last;
  } frame_result_t;

  logic clk = 1'b0;
  logic rst_n;

  epd_in_if  in_ch();
  epd_out_if out_ch();
  epd_cfg_if cfg_ch();

  escaped_packet_deframer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Deframer shadow: codes, parse state, payload bytes, and results still owed.
  byte_t            pred_start  = START_CODE_RST;
  byte_t            pred_escape = ESCAPE_CODE_RST;
  logic             pred_in_pkt = 1'b0;
  logic             pred_esc    = 1'b0;
  logic [6:0]       pred_pos    = '0;
  byte_t            pred_cmd    = '0;
  byte_t            pred_len    = '0;
  byte_t            pred_sum    = '0;
  byte_t            pred_store[STORE_DEPTH];
  frame_result_t    expected_results[$];
  int               error_count = 0;

  // Link-side view of the codes, used to build traffic.
  byte_t      link_start    = START_CODE_RST;
  byte_t      link_escape   = ESCAPE_CODE_RST;
  bit         extra_escapes = 1'b0;
  bit         sender_steady = 1'b0;
  int         burst_left    = 0;
  int         items_sent    = 0;
  sink_mode_t sink_mode     = SINK_OPEN;
  logic [15:0] stall_pattern = 16'hB7DE;
  logic [3:0] pat_phase     = '0;
  int         hold_left     = 0;

  function automatic void deframe_byte(byte_t rx);
    byte_t         v;
    int            count;
    frame_result_t r;
    if (rx == pred_start) begin
      pred_in_pkt = 1'b1;
      pred_esc    = 1'b0;
      pred_pos    = 7'd1;
      pred_sum    = rx;
      return;
    end
    if (!pred_in_pkt) return;
    if (rx == pred_escape) begin
      pred_esc = 1'b1;
      return;
    end
    v        = rx + byte_t'(pred_esc);
    pred_esc = 1'b0;
    if (pred_pos == 7'd1) begin
      pred_cmd = v;
      pred_sum += v;
      pred_pos = 7'd2;
    end else if (pred_pos == 7'd2) begin
      pred_len = v;
      pred_sum += v;
      // drop a packet that cannot fit and go back to hunting
      if (int'(v) + FRAME_EXTRA > BUF_BYTES) begin
        pred_in_pkt = 1'b0;
        pred_pos    = '0;
      end else begin
        pred_pos = 7'(HDR_BYTES);
      end
    end else if (int'(pred_pos) < int'(pred_len) + HDR_BYTES) begin
      if (int'(pred_pos) - HDR_BYTES < STORE_DEPTH) pred_store[int'(pred_pos) - HDR_BYTES] = v;
      pred_sum += v;
      pred_pos = pred_pos + 7'd1;
    end else begin
      r.command        = pred_cmd;
      r.payload_length = pred_len[LEN_W-1:0];
      r.checksum_ok    = (byte_t'(0 - pred_sum) == v);
      count = (int'(pred_len) > STORE_DEPTH) ? STORE_DEPTH : int'(pred_len);
      if (count == 0) begin
        r.has_data   = 1'b0;
        r.data_byte  = '0;
        r.byte_index = '0;
        r.last       = 1'b1;
        expected_results.push_back(r);
      end
      for (int k = 0; k < count; k++) begin
        r.has_data   = 1'b1;
        r.data_byte  = pred_store[k];
        r.byte_index = LEN_W'(k);
        r.last       = (k == count - 1);
        expected_results.push_back(r);
      end
      pred_in_pkt = 1'b0;
      pred_pos    = '0;
    end
  endfunction

  task automatic report_mismatch(string msg);
    if (error_count < MAX_REPORTS) $display("[%0t] MISMATCH %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want)
      report_mismatch($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
  endtask

  task automatic check_result();
    frame_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("result with nothing pending, command 0x%0h", out_ch.command));
      return;
    end
    want = expected_results.pop_front();
    check_field("command", out_ch.command, want.command);
    check_field("payload_length", out_ch.payload_length, want.payload_length);
    check_field("has_data", out_ch.has_data, want.has_data);
    check_field("data_byte", out_ch.data_byte, want.data_byte);
    check_field("byte_index", out_ch.byte_index, want.byte_index);
    check_field("checksum_ok", out_ch.checksum_ok, want.checksum_ok);
    check_field("last", out_ch.last, want.last);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) check_result();
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_START_CODE:  pred_start = cfg_ch.data;
          CFG_ESCAPE_CODE: pred_escape = cfg_ch.data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) deframe_byte(in_ch.rx_byte);
    end
  end

  // Result side: a long hold-off when asked, otherwise the current stall mode.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      case (sink_mode)
        SINK_OPEN:   out_ch.ready <= 1'b1;
        SINK_RANDOM: out_ch.ready <= ($urandom_range(0, 99) < 65);
        default: begin
          out_ch.ready <= stall_pattern[pat_phase];
          pat_phase++;
        end
      endcase
    end
  end

  task automatic shuffle_idling();
    sink_mode     = sink_mode_t'($urandom_range(0, 2));
    sender_steady = ($urandom_range(0, 3) == 0);
    stall_pattern = 16'($urandom) | 16'h0001;
  endtask

  task automatic send_byte(byte_t b);
    int gap;
    if (!sender_steady && burst_left <= 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 4);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  // Send one unescaped value; codes are always escaped, other bytes sometimes.
  task automatic send_value(byte_t v);
    byte_t alt;
    alt = v - 8'd1;
    if (v == link_start || v == link_escape ||
        (extra_escapes && $urandom_range(0, 7) == 0 && alt != link_start && alt != link_escape))
    begin
      send_byte(link_escape);
      send_byte(alt);
    end else begin
      send_byte(v);
    end
  endtask

  task automatic send_packet(byte_t cmd, byte_q_t payload, bit corrupt);
    byte_t sum;
    byte_t check;
    sum = link_start + cmd + byte_t'(payload.size());
    foreach (payload[i]) sum += payload[i];
    check = byte_t'(0 - sum);
    if (corrupt) check ^= byte_t'($urandom_range(1, 255));
    send_byte(link_start);
    send_value(cmd);
    send_value(byte_t'(payload.size()));
    foreach (payload[i]) send_value(payload[i]);
    send_value(check);
  endtask

  function automatic byte_q_t random_payload(int n);
    byte_q_t q;
    repeat (n) q.push_back(byte_t'($urandom));
    return q;
  endfunction

  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_codes(byte_t start_v, byte_t escape_v, bit poke_unmapped);
    logic [CFG_IDX_W-1:0] idx[3];
    byte_t                val[3];
    int                   n;
    settle();
    idx[0] = CFG_START_CODE;
    val[0] = start_v;
    idx[1] = UNMAPPED_REG;
    val[1] = byte_t'($urandom);
    idx[2] = CFG_ESCAPE_CODE;
    val[2] = escape_v;
    for (int i = 0; i < 3; i++) begin
      if (i != 1 || poke_unmapped) begin
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx[i];
        cfg_ch.data  <= val[i];
        do @(posedge clk); while (!cfg_ch.ready);
      end
    end
    cfg_ch.valid <= 1'b0;
    link_start  = start_v;
    link_escape = escape_v;
  endtask

  task automatic test_framing_basics();
    byte_q_t p;
    sink_mode     = SINK_RANDOM;
    sender_steady = 1'b0;
    extra_escapes = 1'b0;
    // an escape and stray bytes before any start are ignored
    send_byte(link_escape);
    send_byte(8'h00);
    send_byte(8'h41);
    p.delete();
    send_packet(8'h00, p, 1'b0);
    p = {8'hFF, 8'hFD, 8'h00};
    send_packet(8'hFF, p, 1'b1);
    // a start code in mid packet drops the partial packet
    send_byte(link_start);
    send_value(8'h12);
    send_value(8'd5);
    send_value(8'hAA);
    p = {8'h5A};
    send_packet(8'h34, p, 1'b0);
    // a second escape while one is pending is dropped: 0x10 arrives as 0x11
    send_byte(link_start);
    send_value(8'h55);
    send_value(8'd1);
    send_byte(link_escape);
    send_byte(link_escape);
    send_byte(8'h10);
    send_value(byte_t'(0 - (link_start + 8'h55 + 8'h01 + 8'h11)));
    // lengths past the store are discarded at the length byte
    send_byte(link_start);
    send_value(8'h01);
    send_value(8'd61);
    send_byte(8'h00);
    send_byte(link_start);
    send_value(8'h02);
    send_value(8'd255);
    send_byte(8'h00);
    settle();
  endtask

  task automatic test_code_registers();
    byte_q_t p;
    program_codes(8'h00, 8'h80, 1'b1);
    // command 0 equals the start code, so it goes out as escape + 0xFF and wraps to 0
    p = {8'hFF, 8'h80, 8'h00, 8'h7F};
    send_packet(8'h00, p, 1'b0);
    // move the escape code between command and length
    send_byte(link_start);
    send_value(8'h21);
    program_codes(link_start, 8'h21, 1'b0);
    send_value(8'd1);
    send_value(8'h21);
    send_value(byte_t'(0 - (link_start + 8'h21 + 8'h01 + 8'h21)));
    settle();
  endtask

  task automatic test_output_hold_off();
    program_codes(START_CODE_RST, ESCAPE_CODE_RST, 1'b0);
    sink_mode     = SINK_OPEN;
    sender_steady = 1'b1;
    // hold the result side off so the full store backs up into the input
    hold_left = HOLD_OFF_CYCLES;
    send_packet(8'hA5, random_payload(STORE_DEPTH), 1'b0);
    send_packet(8'h5A, random_payload(3), 1'b0);
    send_packet(8'hC3, random_payload(0), 1'b1);
    settle();
  endtask

  task automatic test_random_traffic(byte_t start_v, byte_t escape_v, int item_goal);
    int goal;
    int pick;
    int len;
    program_codes(start_v, escape_v, $urandom_range(0, 1));
    extra_escapes = 1'b1;
    shuffle_idling();
    goal = items_sent + item_goal;
    while (items_sent < goal) begin
      if ($urandom_range(0, 15) == 0) shuffle_idling();
      pick = $urandom_range(0, 99);
      len  = (pick < 75) ? $urandom_range(0, 6) :
             (pick < 95) ? $urandom_range(7, 24) : $urandom_range(40, STORE_DEPTH);
      pick = $urandom_range(0, 99);
      if (pick < 68) begin
        send_packet(byte_t'($urandom), random_payload(len), $urandom_range(0, 6) == 0);
      end else if (pick < 78) begin
        // packet cut short, usually by the next start
        send_byte(link_start);
        send_value(byte_t'($urandom));
        len = $urandom_range(1, 20);
        send_value(byte_t'(len));
        repeat ($urandom_range(0, len - 1)) send_value(byte_t'($urandom));
      end else if (pick < 86) begin
        repeat ($urandom_range(1, 4)) send_byte(byte_t'($urandom));
      end else if (pick < 93) begin
        send_byte(link_start);
        send_value(byte_t'($urandom));
        send_value(byte_t'($urandom_range(61, 255)));
        repeat ($urandom_range(0, 3)) send_byte(byte_t'($urandom));
      end else begin
        repeat ($urandom_range(1, 3)) begin
          case ($urandom_range(0, 2))
            0:       send_byte(link_start);
            1:       send_byte(link_escape);
            default: send_byte(byte_t'($urandom));
          endcase
        end
      end
    end
    settle();
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= '0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.index  <= '0;
    cfg_ch.data   <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_framing_basics();
    test_code_registers();
    test_output_hold_off();
    test_random_traffic(START_CODE_RST, ESCAPE_CODE_RST, RANDOM_ITEMS / 4);
    test_random_traffic(8'h00, 8'hFF, RANDOM_ITEMS / 4);
    test_random_traffic(8'h7E, 8'h7D, RANDOM_ITEMS / 4);
    test_random_traffic(byte_t'($urandom), byte_t'($urandom), RANDOM_ITEMS / 4);
    settle();
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("[%0t] TIMEOUT: %0d results still pending", $realtime, expected_results.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/epd_pkg.sv
hw/rtl/epd_if.sv
hw/rtl/epd_ram.sv
hw/rtl/epd_parser.sv
hw/rtl/epd_emitter.sv
hw/rtl/escaped_packet_deframer.sv
tb/tb_escaped_packet_deframer.sv
